// ----- hdl/sfts_pkg.sv -----
`timescale 1ns / 1ps
package sfts_pkg;

  localparam int MAX_COLS  = 64;
  localparam int MAX_ROWS  = 64;
  localparam int CELLS     = MAX_COLS * MAX_ROWS;
  localparam int CELL_W    = $clog2(CELLS);
  localparam int DIM_W     = 7;
  localparam int POS_W     = 6;
  localparam int HALF_W    = 6;
  localparam int COORD_W   = 9;
  localparam int IDX_W     = 15;
  localparam int PROD_W    = 13;
  localparam int LEN_W     = 9;
  localparam int UPC_W     = 4;
  localparam int APB_AW    = 4;
  localparam int APB_DW    = 32;

  localparam logic [DIM_W-1:0] MAX_COLS_C = DIM_W'(MAX_COLS);
  localparam logic [DIM_W-1:0] MAX_ROWS_C = DIM_W'(MAX_ROWS);

  // register indexes
  localparam logic [1:0] REG_GRID_WIDTH  = 2'd0;
  localparam logic [1:0] REG_GRID_HEIGHT = 2'd1;
  localparam logic [1:0] REG_HALF_COLS   = 2'd2;
  localparam logic [1:0] REG_HALF_ROWS   = 2'd3;

  // spiral directions
  localparam logic [1:0] DIR_UP    = 2'd0;
  localparam logic [1:0] DIR_RIGHT = 2'd1;
  localparam logic [1:0] DIR_DOWN  = 2'd2;
  localparam logic [1:0] DIR_LEFT  = 2'd3;

  // micro-program addresses
  localparam logic [UPC_W-1:0] UA_CLEAR   = 4'd0;
  localparam logic [UPC_W-1:0] UA_IDLE    = 4'd1;
  localparam logic [UPC_W-1:0] UA_INDEX   = 4'd2;
  localparam logic [UPC_W-1:0] UA_WRITE   = 4'd3;
  localparam logic [UPC_W-1:0] UA_WAIT0   = 4'd4;
  localparam logic [UPC_W-1:0] UA_TEST0   = 4'd5;
  localparam logic [UPC_W-1:0] UA_MOVE    = 4'd6;
  localparam logic [UPC_W-1:0] UA_WAIT    = 4'd7;
  localparam logic [UPC_W-1:0] UA_TEST    = 4'd8;
  localparam logic [UPC_W-1:0] UA_LEGCHK  = 4'd9;
  localparam logic [UPC_W-1:0] UA_NEXTLEG = 4'd10;
  localparam logic [UPC_W-1:0] UA_HIT     = 4'd11;
  localparam logic [UPC_W-1:0] UA_MISS    = 4'd12;

  typedef enum logic [3:0] {
    UOP_NOP,
    UOP_CLEAR,
    UOP_IDLE,
    UOP_INDEX,
    UOP_WRITE,
    UOP_MOVE,
    UOP_NEXTLEG,
    UOP_HIT,
    UOP_MISS
  } uop_e;

  typedef enum logic [3:0] {
    C_ALWAYS,
    C_CLR_DONE,
    C_ACCEPT,
    C_REQ_WRITE,
    C_NOT_READY,
    C_INB,
    C_LEG_LEFT,
    C_ALL_SEEN,
    C_OUT_FREE
  } cond_e;

  typedef struct packed {
    uop_e             uop;
    cond_e            cond;
    logic [UPC_W-1:0] t_true;
    logic [UPC_W-1:0] t_false;
  } ucw_t;

  typedef struct packed {
    logic clr_done;
    logic accept;
    logic req_write;
    logic not_ready;
    logic inb;
    logic leg_left;
    logic all_seen;
    logic out_free;
  } dp_status_t;

  typedef struct packed {
    logic [DIM_W-1:0]  w_eff;
    logic [DIM_W-1:0]  h_eff;
    logic [HALF_W-1:0] half_cols;
    logic [HALF_W-1:0] half_rows;
  } cfg_t;

  function automatic ucw_t ucode_rom(input logic [UPC_W-1:0] addr);
    ucw_t w;
    case (addr)
      UA_CLEAR:   w = '{UOP_CLEAR,   C_CLR_DONE,  UA_IDLE,    UA_CLEAR};
      UA_IDLE:    w = '{UOP_IDLE,    C_ACCEPT,    UA_INDEX,   UA_IDLE};
      UA_INDEX:   w = '{UOP_INDEX,   C_REQ_WRITE, UA_WRITE,   UA_WAIT0};
      UA_WRITE:   w = '{UOP_WRITE,   C_ALWAYS,    UA_IDLE,    UA_IDLE};
      UA_WAIT0:   w = '{UOP_NOP,     C_ALWAYS,    UA_TEST0,   UA_TEST0};
      UA_TEST0:   w = '{UOP_NOP,     C_NOT_READY, UA_HIT,     UA_MOVE};
      UA_MOVE:    w = '{UOP_MOVE,    C_INB,       UA_WAIT,    UA_LEGCHK};
      UA_WAIT:    w = '{UOP_NOP,     C_ALWAYS,    UA_TEST,    UA_TEST};
      UA_TEST:    w = '{UOP_NOP,     C_NOT_READY, UA_HIT,     UA_LEGCHK};
      UA_LEGCHK:  w = '{UOP_NOP,     C_LEG_LEFT,  UA_MOVE,    UA_NEXTLEG};
      UA_NEXTLEG: w = '{UOP_NEXTLEG, C_ALL_SEEN,  UA_MISS,    UA_MOVE};
      UA_HIT:     w = '{UOP_HIT,     C_OUT_FREE,  UA_IDLE,    UA_HIT};
      UA_MISS:    w = '{UOP_MISS,    C_OUT_FREE,  UA_IDLE,    UA_MISS};
      default:    w = '{UOP_NOP,     C_ALWAYS,    UA_IDLE,    UA_IDLE};
    endcase
    return w;
  endfunction

endpackage

// ----- hdl/sfts_if.sv -----
`timescale 1ns / 1ps
interface sfts_req_if import sfts_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             req_type;
  logic [POS_W-1:0] tile_x;
  logic [POS_W-1:0] tile_y;
  logic             tile_ready;
  logic             use_window;

  modport source (output valid, req_type, tile_x, tile_y, tile_ready, use_window,
                  input ready);
  modport sink   (input valid, req_type, tile_x, tile_y, tile_ready, use_window,
                  output ready);
endinterface

interface sfts_rsp_if import sfts_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              found;
  logic [CELL_W-1:0] tile_index;

  modport source (output valid, found, tile_index, input ready);
  modport sink   (input valid, found, tile_index, output ready);
endinterface

// ----- hdl/sfts_seq.sv -----
`timescale 1ns / 1ps
module sfts_seq import sfts_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  dp_status_t status_i,
  output ucw_t       ucw_o
);

  logic [UPC_W-1:0] upc_q, upc_d;
  ucw_t             ucw;
  logic             cond_ok;

  assign ucw   = ucode_rom(upc_q);
  assign ucw_o = ucw;

  always_comb begin
    case (ucw.cond)
      C_ALWAYS:    cond_ok = 1'b1;
      C_CLR_DONE:  cond_ok = status_i.clr_done;
      C_ACCEPT:    cond_ok = status_i.accept;
      C_REQ_WRITE: cond_ok = status_i.req_write;
      C_NOT_READY: cond_ok = status_i.not_ready;
      C_INB:       cond_ok = status_i.inb;
      C_LEG_LEFT:  cond_ok = status_i.leg_left;
      C_ALL_SEEN:  cond_ok = status_i.all_seen;
      C_OUT_FREE:  cond_ok = status_i.out_free;
      default:     cond_ok = 1'b1;
    endcase
    upc_d = cond_ok ? ucw.t_true : ucw.t_false;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= UA_CLEAR;
    end else begin
      upc_q <= upc_d;
    end
  end

endmodule

// ----- hdl/sfts_dpath.sv -----
`timescale 1ns / 1ps
module sfts_dpath import sfts_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ucw_t              ucw_i,
  input  cfg_t              cfg_i,
  input  logic              req_valid_i,
  output logic              req_ready_o,
  input  logic              req_type_i,
  input  logic [POS_W-1:0]  tile_x_i,
  input  logic [POS_W-1:0]  tile_y_i,
  input  logic              tile_ready_i,
  input  logic              use_window_i,
  output logic              rsp_valid_o,
  input  logic              rsp_ready_i,
  output logic              found_o,
  output logic [CELL_W-1:0] tile_index_o,
  output dp_status_t        status_o
);

  localparam logic signed [COORD_W-1:0] ONE_C = COORD_W'(1);
  localparam logic signed [COORD_W-1:0] ZERO_C = '0;

  logic                       mem_q [CELLS];
  logic                       rd_q;
  logic [CELL_W-1:0]          clr_q;

  logic                       req_write_q, tile_ready_q, use_window_q;
  logic signed [COORD_W-1:0]  x_q, y_q;
  logic signed [IDX_W-1:0]    idx_q;
  logic signed [COORD_W-1:0]  xlo_q, xhi_q, ylo_q, yhi_q;
  logic                       seen_l_q, seen_r_q, seen_d_q, seen_u_q;
  logic [1:0]                 dir_q;
  logic [LEN_W-1:0]           len_q, cnt_q;
  logic                       rsp_valid_q, found_q;
  logic [CELL_W-1:0]          tile_index_q;

  logic                       accept, out_free;
  logic [POS_W-1:0]           xc, yc;
  logic [DIM_W-1:0]           w_m1, h_m1;
  logic [PROD_W-1:0]          prod;
  logic signed [COORD_W-1:0]  w_s, h_s, hc_s, hr_s;
  logic signed [COORD_W-1:0]  xlo_c, xhi_c, ylo_c, yhi_c;
  logic signed [COORD_W-1:0]  nx, ny;
  logic signed [IDX_W-1:0]    nidx, w_idx;
  logic                       hit_l, hit_r, hit_d, hit_u, inb;
  logic [LEN_W-1:0]           len_next;

  assign req_ready_o = (ucw_i.uop == UOP_IDLE);
  assign accept      = req_valid_i && req_ready_o;
  assign out_free    = !rsp_valid_q || rsp_ready_i;

  // clamp the incoming coordinate into the grid
  assign w_m1 = cfg_i.w_eff - DIM_W'(1);
  assign h_m1 = cfg_i.h_eff - DIM_W'(1);
  assign xc   = ({1'b0, tile_x_i} > w_m1) ? w_m1[POS_W-1:0] : tile_x_i;
  assign yc   = ({1'b0, tile_y_i} > h_m1) ? h_m1[POS_W-1:0] : tile_y_i;

  assign prod  = PROD_W'(y_q[POS_W-1:0]) * PROD_W'(cfg_i.w_eff);
  assign w_s   = $signed(COORD_W'(cfg_i.w_eff));
  assign h_s   = $signed(COORD_W'(cfg_i.h_eff));
  assign hc_s  = $signed(COORD_W'(cfg_i.half_cols));
  assign hr_s  = $signed(COORD_W'(cfg_i.half_rows));
  assign w_idx = $signed(IDX_W'(cfg_i.w_eff));

  always_comb begin
    xlo_c = x_q - hc_s;
    ylo_c = y_q - hr_s;
    xhi_c = x_q + hc_s + ONE_C;
    yhi_c = y_q + hr_s + ONE_C;
    if (xlo_c < ZERO_C) xlo_c = ZERO_C;
    if (ylo_c < ZERO_C) ylo_c = ZERO_C;
    if (xhi_c > w_s) xhi_c = w_s;
    if (yhi_c > h_s) yhi_c = h_s;
  end

  // next spiral position and its bound checks
  always_comb begin
    nx   = x_q;
    ny   = y_q;
    nidx = idx_q;
    case (dir_q)
      DIR_UP: begin
        ny   = y_q + ONE_C;
        nidx = idx_q + w_idx;
      end
      DIR_RIGHT: begin
        nx   = x_q + ONE_C;
        nidx = idx_q + IDX_W'(1);
      end
      DIR_DOWN: begin
        ny   = y_q - ONE_C;
        nidx = idx_q - w_idx;
      end
      DIR_LEFT: begin
        nx   = x_q - ONE_C;
        nidx = idx_q - IDX_W'(1);
      end
      default: begin
        nx = x_q;
      end
    endcase
    hit_l = nx < xlo_q;
    hit_r = !hit_l && (nx >= xhi_q);
    hit_d = !hit_l && !hit_r && (ny < ylo_q);
    hit_u = !hit_l && !hit_r && !hit_d && (ny >= yhi_q);
    inb   = !hit_l && !hit_r && !hit_d && !hit_u;
  end

  assign len_next = len_q + LEN_W'(dir_q[0]);

  assign status_o = '{
    clr_done:  &clr_q,
    accept:    accept,
    req_write: req_write_q,
    not_ready: !rd_q,
    inb:       inb,
    leg_left:  cnt_q != '0,
    all_seen:  seen_l_q && seen_r_q && seen_d_q && seen_u_q,
    out_free:  out_free
  };

  // ready bit store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (ucw_i.uop == UOP_CLEAR) begin
      mem_q[clr_q] <= 1'b0;
    end else if (ucw_i.uop == UOP_WRITE) begin
      mem_q[idx_q[CELL_W-1:0]] <= tile_ready_q;
    end
    rd_q <= mem_q[idx_q[CELL_W-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q       <= '0;
      rsp_valid_q <= 1'b0;
      seen_l_q    <= 1'b0;
      seen_r_q    <= 1'b0;
      seen_d_q    <= 1'b0;
      seen_u_q    <= 1'b0;
      dir_q       <= DIR_UP;
      len_q       <= '0;
      cnt_q       <= '0;
    end else begin
      if ((ucw_i.uop == UOP_HIT || ucw_i.uop == UOP_MISS) && out_free) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_valid_q && rsp_ready_i) begin
        rsp_valid_q <= 1'b0;
      end
      case (ucw_i.uop)
        UOP_CLEAR: begin
          clr_q <= clr_q + CELL_W'(1);
        end
        UOP_INDEX: begin
          seen_l_q <= 1'b0;
          seen_r_q <= 1'b0;
          seen_d_q <= 1'b0;
          seen_u_q <= 1'b0;
          dir_q    <= DIR_UP;
          len_q    <= LEN_W'(1);
          cnt_q    <= LEN_W'(1);
        end
        UOP_MOVE: begin
          cnt_q <= cnt_q - LEN_W'(1);
          if (hit_l) seen_l_q <= 1'b1;
          if (hit_r) seen_r_q <= 1'b1;
          if (hit_d) seen_d_q <= 1'b1;
          if (hit_u) seen_u_q <= 1'b1;
        end
        UOP_NEXTLEG: begin
          dir_q <= dir_q + 2'd1;
          len_q <= len_next;
          cnt_q <= len_next;
        end
        default: begin
          clr_q <= clr_q;
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    case (ucw_i.uop)
      UOP_IDLE: begin
        if (accept) begin
          req_write_q  <= !req_type_i;
          tile_ready_q <= tile_ready_i;
          use_window_q <= use_window_i;
          x_q          <= $signed(COORD_W'(xc));
          y_q          <= $signed(COORD_W'(yc));
        end
      end
      UOP_INDEX: begin
        idx_q <= $signed(IDX_W'(prod)) + $signed(IDX_W'(x_q[POS_W-1:0]));
        if (use_window_q) begin
          xlo_q <= xlo_c;
          xhi_q <= xhi_c;
          ylo_q <= ylo_c;
          yhi_q <= yhi_c;
        end else begin
          xlo_q <= ZERO_C;
          xhi_q <= w_s;
          ylo_q <= ZERO_C;
          yhi_q <= h_s;
        end
      end
      UOP_MOVE: begin
        x_q   <= nx;
        y_q   <= ny;
        idx_q <= nidx;
      end
      UOP_HIT: begin
        if (out_free) begin
          found_q      <= 1'b1;
          tile_index_q <= idx_q[CELL_W-1:0];
        end
      end
      UOP_MISS: begin
        if (out_free) begin
          found_q      <= 1'b0;
          tile_index_q <= '0;
        end
      end
      default: begin
        x_q <= x_q;
      end
    endcase
  end

  assign rsp_valid_o  = rsp_valid_q;
  assign found_o      = found_q;
  assign tile_index_o = tile_index_q;

endmodule

// ----- hdl/spiral_free_tile_search.sv -----
`timescale 1ns / 1ps
// Write transaction: the micro-program runs INDEX and WRITE, then returns to IDLE. Search: when
// the start tile is not ready, the result register loads in HIT after INDEX, WAIT0 and TEST0,
// once the output register is free; a spiral step runs MOVE, WAIT, TEST and LEGCHK inside the
// bounds and MOVE and LEGCHK outside, plus NEXTLEG per leg, through the single read port of the
// ready store. One transaction at a time; a finished result waits in an output register.
// Reset: registers to defaults, then a clearing pass over all 4096 ready bits before requests.
module spiral_free_tile_search import sfts_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  sfts_req_if.sink          req_i,
  sfts_rsp_if.source        rsp_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  logic [DIM_W-1:0]  grid_width_q, grid_height_q;
  logic [HALF_W-1:0] half_cols_q, half_rows_q;
  logic [1:0]        reg_idx;
  logic              cfg_we;
  cfg_t              cfg;
  ucw_t              ucw;
  dp_status_t        status;

  assign reg_idx = paddr[3:2];
  assign cfg_we  = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_width_q  <= MAX_COLS_C;
      grid_height_q <= MAX_ROWS_C;
      half_cols_q   <= HALF_W'(1);
      half_rows_q   <= HALF_W'(1);
    end else if (cfg_we) begin
      case (reg_idx)
        REG_GRID_WIDTH:  grid_width_q  <= pwdata[DIM_W-1:0];
        REG_GRID_HEIGHT: grid_height_q <= pwdata[DIM_W-1:0];
        REG_HALF_COLS:   half_cols_q   <= pwdata[HALF_W-1:0];
        REG_HALF_ROWS:   half_rows_q   <= pwdata[HALF_W-1:0];
        default:         grid_width_q  <= grid_width_q;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_GRID_WIDTH:  prdata = APB_DW'(grid_width_q);
      REG_GRID_HEIGHT: prdata = APB_DW'(grid_height_q);
      REG_HALF_COLS:   prdata = APB_DW'(half_cols_q);
      REG_HALF_ROWS:   prdata = APB_DW'(half_rows_q);
      default:         prdata = '0;
    endcase
  end

  // effective grid size, clamped into 1..max
  always_comb begin
    cfg.w_eff = grid_width_q;
    if (grid_width_q == '0) cfg.w_eff = DIM_W'(1);
    else if (grid_width_q > MAX_COLS_C) cfg.w_eff = MAX_COLS_C;
    cfg.h_eff = grid_height_q;
    if (grid_height_q == '0) cfg.h_eff = DIM_W'(1);
    else if (grid_height_q > MAX_ROWS_C) cfg.h_eff = MAX_ROWS_C;
    cfg.half_cols = half_cols_q;
    cfg.half_rows = half_rows_q;
  end

  sfts_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .ucw_o    (ucw)
  );

  sfts_dpath u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ucw_i        (ucw),
    .cfg_i        (cfg),
    .req_valid_i  (req_i.valid),
    .req_ready_o  (req_i.ready),
    .req_type_i   (req_i.req_type),
    .tile_x_i     (req_i.tile_x),
    .tile_y_i     (req_i.tile_y),
    .tile_ready_i (req_i.tile_ready),
    .use_window_i (req_i.use_window),
    .rsp_valid_o  (rsp_o.valid),
    .rsp_ready_i  (rsp_o.ready),
    .found_o      (rsp_o.found),
    .tile_index_o (rsp_o.tile_index),
    .status_o     (status)
  );

endmodule

// ----- verif/tb_spiral_free_tile_search.sv -----
`timescale 1ns / 1ps
module tb_spiral_free_tile_search;
  import sfts_pkg::*;

  localparam logic REQ_WRITE  = 1'b0;
  localparam logic REQ_SEARCH = 1'b1;

  localparam int LEG_LIMIT       = 4 * (MAX_COLS + MAX_ROWS) + 16;
  localparam int SETTLE_CYCLES   = 8;
  localparam int HOLD_CYCLES     = 400;
  localparam int PHASES          = 12;
  localparam int ITEMS_PER_PHASE = 110;
  localparam int RUN_LIMIT_NS    = 60_000_000;

  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_e;

  typedef struct packed {
    logic             req_type;
    logic [POS_W-1:0] tile_x;
    logic [POS_W-1:0] tile_y;
    logic             tile_ready;
    logic             use_window;
  } tile_req_t;

  typedef struct packed {
    logic              found;
    logic [CELL_W-1:0] tile_index;
  } tile_rsp_t;

  typedef struct packed {
    bit        given;
    tile_rsp_t rsp;
  } fixed_answer_t;

  typedef struct packed {
    row_kind_e  kind;
    logic [1:0] reg_idx;
    int         value;
    tile_req_t  req;
    bit         typed;
    tile_rsp_t  answer;
  } stim_row_t;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  sfts_req_if req_if ();
  sfts_rsp_if rsp_if ();

  spiral_free_tile_search DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_if),
    .rsp_o   (rsp_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #1 clk_i = ~clk_i;

  // shadow of the block: ready bits and registers
  bit               ready_map [CELLS];
  logic [DIM_W-1:0]  cfg_w  = DIM_W'(64);
  logic [DIM_W-1:0]  cfg_h  = DIM_W'(64);
  logic [HALF_W-1:0] cfg_hc = HALF_W'(1);
  logic [HALF_W-1:0] cfg_hr = HALF_W'(1);

  tile_rsp_t     tile_answers_q [$];
  fixed_answer_t fixed_answers_q [$];
  int            mismatch_count = 0;
  bit            steady_flow;
  bit            hold_go;
  bit            hold_rx;

  int phase_w  [PHASES] = '{64, 8, 1, 127, 5, 0, 64, 12, 4, 100, 3, 2};
  int phase_h  [PHASES] = '{64, 8, 1, 3, 12, 64, 1, 12, 4, 100, 7, 2};
  int phase_hc [PHASES] = '{1, 2, 0, 63, 0, 3, 63, 63, 1, 2, 0, 1};
  int phase_hr [PHASES] = '{1, 2, 0, 0, 63, 3, 63, 63, 1, 3, 1, 0};

  task automatic report_mismatch(input string what);
    $display("%0t ERROR %s", $time, what);
    mismatch_count++;
  endtask

  function automatic int dim_in_use(input logic [DIM_W-1:0] v, input int cap);
    if (int'(v) < 1) return 1;
    if (int'(v) > cap) return cap;
    return int'(v);
  endfunction

  // Apply one transaction to the shadow grid; return 1 where it gives a result.
  function automatic bit walk_spiral(input tile_req_t r, output tile_rsp_t ans);
    int w, h, x, y, xlo, xhi, ylo, yhi, len, dx, dy;
    bit past_l, past_r, past_u, past_d;
    w = dim_in_use(cfg_w, MAX_COLS);
    h = dim_in_use(cfg_h, MAX_ROWS);
    x = (int'(r.tile_x) > w - 1) ? w - 1 : int'(r.tile_x);
    y = (int'(r.tile_y) > h - 1) ? h - 1 : int'(r.tile_y);
    past_l = 1'b0;
    past_r = 1'b0;
    past_u = 1'b0;
    past_d = 1'b0;
    ans.found = 1'b0;
    ans.tile_index = '0;
    if (r.req_type == REQ_WRITE) begin
      ready_map[y * w + x] = r.tile_ready;
      return 1'b0;
    end
    if (!ready_map[y * w + x]) begin
      ans.found = 1'b1;
      ans.tile_index = CELL_W'(y * w + x);
      return 1'b1;
    end
    if (r.use_window) begin
      xlo = (x - int'(cfg_hc) < 0) ? 0 : x - int'(cfg_hc);
      ylo = (y - int'(cfg_hr) < 0) ? 0 : y - int'(cfg_hr);
      xhi = (x + int'(cfg_hc) + 1 > w) ? w : x + int'(cfg_hc) + 1;
      yhi = (y + int'(cfg_hr) + 1 > h) ? h : y + int'(cfg_hr) + 1;
    end else begin
      xlo = 0;
      xhi = w;
      ylo = 0;
      yhi = h;
    end
    for (int leg = 0; leg < LEG_LIMIT; leg++) begin
      len = leg / 2 + 1;
      case (2'(leg))
        DIR_UP: begin
          dx = 0;
          dy = 1;
        end
        DIR_RIGHT: begin
          dx = 1;
          dy = 0;
        end
        DIR_DOWN: begin
          dx = 0;
          dy = -1;
        end
        default: begin
          dx = -1;
          dy = 0;
        end
      endcase
      for (int k = 0; k < len; k++) begin
        x += dx;
        y += dy;
        // x bounds first; y only counts once x is in range
        if (x < xlo) past_l = 1'b1;
        else if (x >= xhi) past_r = 1'b1;
        else if (y < ylo) past_d = 1'b1;
        else if (y >= yhi) past_u = 1'b1;
        else if (!ready_map[y * w + x]) begin
          ans.found = 1'b1;
          ans.tile_index = CELL_W'(y * w + x);
          return 1'b1;
        end
      end
      if (past_l && past_r && past_u && past_d) break;
    end
    return 1'b1;
  endfunction

  function automatic stim_row_t cfg_row(input logic [1:0] idx, input int value);
    stim_row_t row;
    row = '0;
    row.kind = ROW_CFG;
    row.reg_idx = idx;
    row.value = value;
    return row;
  endfunction

  function automatic stim_row_t req_row(input logic rtype, input int x, input int y,
                                        input logic rdy, input logic win, input bit typed,
                                        input logic found, input int index);
    stim_row_t row;
    row = '0;
    row.kind = ROW_REQ;
    row.req = '{rtype, POS_W'(x), POS_W'(y), rdy, win};
    row.typed = typed;
    row.answer = '{found, CELL_W'(index)};
    return row;
  endfunction

  // APB write followed by a read-back of the same register
  task automatic program_register(input logic [1:0] idx, input int value);
    logic [APB_DW-1:0] mask;
    mask = (idx == REG_GRID_WIDTH || idx == REG_GRID_HEIGHT) ? 'h7F : 'h3F;
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = APB_AW'({idx, 2'b00});
    pwdata = APB_DW'(value);
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    penable = 1'b0;
    pwrite = 1'b0;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata !== (APB_DW'(value) & mask))
      report_mismatch($sformatf("register %0d reads %0h, wrote %0h", idx, prdata, value));
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
    case (idx)
      REG_GRID_WIDTH:  cfg_w = DIM_W'(value);
      REG_GRID_HEIGHT: cfg_h = DIM_W'(value);
      REG_HALF_COLS:   cfg_hc = HALF_W'(value);
      default:         cfg_hr = HALF_W'(value);
    endcase
  endtask

  task automatic offer_tile_req(input tile_req_t r, input bit typed, input tile_rsp_t answer);
    int gap;
    fixed_answers_q.push_back('{typed, answer});
    gap = steady_flow ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      req_if.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_if.req_type = r.req_type;
    req_if.tile_x = r.tile_x;
    req_if.tile_y = r.tile_y;
    req_if.tile_ready = r.tile_ready;
    req_if.use_window = r.use_window;
    req_if.valid = 1'b1;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Drop valid, let every search finish, then give a trailing write time to land.
  task automatic wait_idle();
    req_if.valid = 1'b0;
    while (tile_answers_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  always @(posedge clk_i) begin : watch_req
    tile_req_t     seen;
    tile_rsp_t     guess;
    fixed_answer_t fixed;
    if (rst_ni && req_if.valid && req_if.ready) begin
      seen = '{req_if.req_type, req_if.tile_x, req_if.tile_y, req_if.tile_ready,
               req_if.use_window};
      fixed = fixed_answers_q.pop_front();
      if (walk_spiral(seen, guess))
        tile_answers_q.push_back(fixed.given ? fixed.rsp : guess);
    end
  end

  always @(posedge clk_i) begin : check_rsp
    tile_rsp_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (tile_answers_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result found=%0b index=%0d",
                                  rsp_if.found, rsp_if.tile_index));
      end else begin
        want = tile_answers_q.pop_front();
        if (rsp_if.found !== want.found)
          report_mismatch($sformatf("found %0b, wanted %0b", rsp_if.found, want.found));
        if (rsp_if.tile_index !== want.tile_index)
          report_mismatch($sformatf("tile_index %0d, wanted %0d",
                                    rsp_if.tile_index, want.tile_index));
      end
    end
  end

  // long hold-off on the result side so the block backs up into its input
  initial begin : rx_hold_off
    hold_rx = 1'b0;
    wait (hold_go);
    @(posedge clk_i);
    hold_rx = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_rx = 1'b0;
  end

  initial begin : rsp_drain
    int stall;
    rsp_if.ready = 1'b0;
    wait (rst_ni === 1'b1);
    @(negedge clk_i);
    forever begin
      stall = steady_flow ? 0 : $urandom_range(0, 15);
      if (stall > 0 || hold_rx) begin
        rsp_if.ready = 1'b0;
        repeat (stall) @(negedge clk_i);
        while (hold_rx) @(negedge clk_i);
      end
      rsp_if.ready = 1'b1;
      @(posedge clk_i);
      while (!rsp_if.valid) @(posedge clk_i);
      @(negedge clk_i);
    end
  end

  initial begin : watchdog
    #(RUN_LIMIT_NS);
    $display("spiral_free_tile_search verification failed");
    $finish;
  end

  initial begin : stimulus
    stim_row_t plan [$];
    tile_req_t r;
    tile_rsp_t no_answer;
    int        wx, hy, cx, cy, spread, pick, rx, ry;

    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    req_if.valid = 1'b0;
    req_if.req_type = REQ_WRITE;
    req_if.tile_x = '0;
    req_if.tile_y = '0;
    req_if.tile_ready = 1'b0;
    req_if.use_window = 1'b0;
    steady_flow = 1'b0;
    hold_go = 1'b0;
    no_answer = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed rows under the reset settings, then the odd grid sizes
    plan.push_back(req_row(REQ_SEARCH, 0, 0, 0, 0, 1'b1, 1'b1, 0));
    plan.push_back(req_row(REQ_SEARCH, 63, 63, 1, 1, 1'b1, 1'b1, 4095));
    plan.push_back(req_row(REQ_WRITE, 0, 0, 1, 0, 1'b0, 1'b0, 0));
    plan.push_back(req_row(REQ_SEARCH, 0, 0, 0, 1, 1'b0, 1'b0, 0));
    plan.push_back(req_row(REQ_WRITE, 63, 63, 1, 1, 1'b0, 1'b0, 0));
    plan.push_back(req_row(REQ_SEARCH, 63, 63, 0, 1, 1'b0, 1'b0, 0));
    plan.push_back(req_row(REQ_WRITE, 0, 1, 1, 0, 1'b0, 1'b0, 0));
    plan.push_back(req_row(REQ_WRITE, 1, 0, 1, 1, 1'b0, 1'b0, 0));
    plan.push_back(req_row(REQ_WRITE, 1, 1, 1, 0, 1'b0, 1'b0, 0));
    // 2x2 window around the corner is fully ready
    plan.push_back(req_row(REQ_SEARCH, 0, 0, 1, 1, 1'b1, 1'b0, 0));
    plan.push_back(req_row(REQ_SEARCH, 0, 0, 0, 0, 1'b0, 1'b0, 0));
    // zero width and height fall back to a single tile
    plan.push_back(cfg_row(REG_GRID_WIDTH, 0));
    plan.push_back(cfg_row(REG_GRID_HEIGHT, 0));
    plan.push_back(req_row(REQ_SEARCH, 45, 17, 0, 0, 1'b1, 1'b0, 0));
    plan.push_back(req_row(REQ_WRITE, 63, 63, 0, 1, 1'b0, 1'b0, 0));
    plan.push_back(req_row(REQ_SEARCH, 63, 63, 1, 1, 1'b1, 1'b1, 0));
    // oversized width saturates; start row clamps to the last row
    plan.push_back(cfg_row(REG_GRID_WIDTH, 127));
    plan.push_back(cfg_row(REG_GRID_HEIGHT, 2));
    plan.push_back(cfg_row(REG_HALF_COLS, 63));
    plan.push_back(cfg_row(REG_HALF_ROWS, 0));
    plan.push_back(req_row(REQ_SEARCH, 63, 63, 0, 1, 1'b1, 1'b1, 127));
    plan.push_back(req_row(REQ_WRITE, 10, 63, 1, 0, 1'b0, 1'b0, 0));
    plan.push_back(req_row(REQ_SEARCH, 10, 1, 1, 1, 1'b0, 1'b0, 0));
    // narrow the grid so earlier bits land on new tiles
    plan.push_back(cfg_row(REG_GRID_WIDTH, 2));
    plan.push_back(cfg_row(REG_GRID_HEIGHT, 65));
    plan.push_back(cfg_row(REG_HALF_COLS, 0));
    plan.push_back(cfg_row(REG_HALF_ROWS, 1));
    plan.push_back(req_row(REQ_SEARCH, 1, 0, 0, 0, 1'b0, 1'b0, 0));
    plan.push_back(req_row(REQ_SEARCH, 0, 32, 1, 1, 1'b0, 1'b0, 0));

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        wait_idle();
        program_register(plan[i].reg_idx, plan[i].value);
      end else begin
        offer_tile_req(plan[i].req, plan[i].typed, plan[i].answer);
      end
    end

    // each phase writes a patch around one spot and searches from inside it, one pick in five at a random tile
    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      program_register(REG_GRID_WIDTH, phase_w[p]);
      program_register(REG_GRID_HEIGHT, phase_h[p]);
      program_register(REG_HALF_COLS, phase_hc[p]);
      program_register(REG_HALF_ROWS, phase_hr[p]);
      steady_flow = (p % 4 == 2);
      if (p == 0) hold_go = 1'b1;
      wx = dim_in_use(DIM_W'(phase_w[p]), MAX_COLS);
      hy = dim_in_use(DIM_W'(phase_h[p]), MAX_ROWS);
      cx = $urandom_range(0, wx - 1);
      cy = $urandom_range(0, hy - 1);
      spread = $urandom_range(0, 3);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        pick = $urandom_range(0, 9);
        if (pick < 8) begin
          rx = cx + int'($urandom_range(0, 2 * spread)) - spread;
          ry = cy + int'($urandom_range(0, 2 * spread)) - spread;
          if (rx < 0) rx = 0;
          if (ry < 0) ry = 0;
        end else begin
          rx = $urandom_range(0, 63);
          ry = $urandom_range(0, 63);
        end
        r.req_type = (pick < 4 || pick == 8) ? REQ_WRITE : REQ_SEARCH;
        r.tile_x = POS_W'(rx);
        r.tile_y = POS_W'(ry);
        // bias patch writes towards ready so searches have to travel
        r.tile_ready = (pick < 4) ? ($urandom_range(0, 2) != 0) : 1'($urandom_range(0, 1));
        r.use_window = 1'($urandom_range(0, 1));
        offer_tile_req(r, 1'b0, no_answer);
      end
    end

    steady_flow = 1'b0;
    wait_idle();
    repeat (32) @(negedge clk_i);
    if (mismatch_count == 0) begin
      $display("spiral_free_tile_search verification clean");
    end else begin
      $display("spiral_free_tile_search verification failed");
    end
    $finish;
  end

endmodule
